[src/lsst_pkg.sv]
// Shared types and constants for the link session sequence tracker.
package lsst_pkg;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned DAT_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] TIMEOUT_RST = 32'd10000;
  localparam logic [CNT_W-1:0] SYNC_RST = 32'd5000;
  localparam logic [SEQ_W-1:0] RESYNC_RST = 32'h0001_0000;

  localparam logic [2:0] PKT_HELLO = 3'd0;
  localparam logic [2:0] PKT_LEVEL = 3'd1;
  localparam logic [2:0] PKT_PING = 3'd2;
  localparam logic [2:0] PKT_BYE = 3'd3;

  localparam logic KIND_TICK = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_SYNC    = 2'd1,
    CFG_RESYNC  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_HELLO,
    OP_LEVEL,
    OP_PING,
    OP_BYE,
    OP_REJECT,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    LINK_DISC  = 2'd0,
    LINK_CONN  = 2'd1,
    LINK_STALE = 2'd2
  } link_t;

  typedef enum logic [2:0] {
    RPL_NONE   = 3'd0,
    RPL_ACK    = 3'd1,
    RPL_PONG   = 3'd2,
    RPL_REJECT = 3'd3,
    RPL_SYNC   = 3'd4
  } reply_t;

  typedef struct packed {
    op_t              op;
    logic             newly;
    logic [SEQ_W-1:0] seq;
    logic [DAT_W-1:0] level;
    logic [DAT_W-1:0] dry_ind;
  } item_t;

  typedef struct packed {
    reply_t           reply;
    logic [SEQ_W-1:0] reply_seq;
    link_t            link_state;
    logic             data_valid;
    logic [DAT_W-1:0] held_level;
    logic [DAT_W-1:0] held_dry_ind;
    logic             fresh_data;
    logic [CNT_W-1:0] lost_total;
    logic [CNT_W-1:0] duplicate_total;
    logic [CNT_W-1:0] out_of_order_total;
  } result_t;

endpackage

[src/lsst_in_if.sv]
// Input event channel: tick or decoded packet event.
interface lsst_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  pkt_type;
  logic        peer_allowed;
  logic        peer_newly_added;
  logic [31:0] seq;
  logic [7:0]  level;
  logic [7:0]  dry_ind;

  modport source (
    output valid, kind, pkt_type, peer_allowed, peer_newly_added, seq, level, dry_ind,
    input  ready
  );
  modport sink (
    input  valid, kind, pkt_type, peer_allowed, peer_newly_added, seq, level, dry_ind,
    output ready
  );
endinterface

[src/lsst_out_if.sv]
// Result channel: reply plus link and counter snapshot.
interface lsst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply;
  logic [31:0] reply_seq;
  logic [1:0]  link_state;
  logic        data_valid;
  logic [7:0]  held_level;
  logic [7:0]  held_dry_ind;
  logic        fresh_data;
  logic [31:0] lost_total;
  logic [31:0] duplicate_total;
  logic [31:0] out_of_order_total;

  modport source (
    output valid, reply, reply_seq, link_state, data_valid, held_level, held_dry_ind,
           fresh_data, lost_total, duplicate_total, out_of_order_total,
    input  ready
  );
  modport sink (
    input  valid, reply, reply_seq, link_state, data_valid, held_level, held_dry_ind,
           fresh_data, lost_total, duplicate_total, out_of_order_total,
    output ready
  );
endinterface

[src/lsst_cfg_if.sv]
// Configuration write channel.
interface lsst_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/link_session_sequence_tracker_core.sv]
// Top level of the link session sequence tracker.
//
//   channel  | direction | handshake   | carries
//   in_ch    | sink      | valid/ready | tick or packet event
//   out_ch   | source    | valid/ready | reply and link/counter snapshot
//   cfg_ch   | sink      | valid/ready | register index and write data
//
// One transaction per cycle in and out while out_ch is not stalled; every input yields
// one result, registered first in the queue and then in the result register.
// Synchronous active-low reset restores register defaults and a disconnected link.
// A stalled out_ch fills the queue of QueueDepth entries, then in_ch.ready drops.
// cfg_ch is always ready; writes take effect on the next cycle.
module link_session_sequence_tracker_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  lsst_in_if.sink    in_ch,
  lsst_out_if.source out_ch,
  lsst_cfg_if.sink   cfg_ch
);
  import lsst_pkg::*;

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_not_empty;
  item_t push_item;
  item_t q_head;

  lsst_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  lsst_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lsst_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

[src/lsst_front.sv]
// Front end: accept input transactions and classify them into queue operations.
module lsst_front (
  lsst_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output lsst_pkg::item_t push_item
);
  import lsst_pkg::*;

  op_t op;

  always_comb begin
    op = OP_NOP;
    if (in_ch.kind == KIND_TICK) begin
      op = OP_TICK;
    end else begin
      case (in_ch.pkt_type)
        PKT_HELLO: op = in_ch.peer_allowed ? OP_HELLO : OP_REJECT;
        PKT_LEVEL: op = in_ch.peer_allowed ? OP_LEVEL : OP_REJECT;
        PKT_PING:  op = in_ch.peer_allowed ? OP_PING : OP_REJECT;
        PKT_BYE:   op = OP_BYE;
        default:   op = OP_NOP;
      endcase
    end
  end

  assign in_ch.ready = ~q_full;
  assign push        = in_ch.valid & ~q_full;

  always_comb begin
    push_item.op      = op;
    push_item.newly   = in_ch.peer_newly_added;
    push_item.seq     = in_ch.seq;
    push_item.level   = in_ch.level;
    push_item.dry_ind = in_ch.dry_ind;
  end

endmodule

[src/lsst_queue.sv]
// Short FIFO between the front end and the execution back end.
module lsst_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lsst_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lsst_pkg::item_t head
);
  import lsst_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntFull);
  assign not_empty = (cnt_r != '0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop)
    else $error("queue pop while empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntFull)
    else $error("queue count out of range");

endmodule

[src/lsst_back.sv]
// Back end: link state, sequence tracking, counters and the result register.
module lsst_back (
  input  logic            clk,
  input  logic            rst_n,
  lsst_cfg_if.sink        cfg_ch,
  input  logic            q_not_empty,
  input  lsst_pkg::item_t q_head,
  output logic            pop,
  lsst_out_if.source      out_ch
);
  import lsst_pkg::*;

  logic [CNT_W-1:0] timeout_r, sync_int_r;
  logic [SEQ_W-1:0] resync_r;

  link_t            mode_r, mode_nxt;
  logic             started_r, started_nxt;
  logic [SEQ_W-1:0] last_seq_r, last_seq_nxt;
  logic             valid_r, valid_nxt;
  logic [DAT_W-1:0] level_r, level_nxt;
  logic [DAT_W-1:0] wd_r, wd_nxt;
  logic [CNT_W-1:0] data_age_r, data_age_nxt;
  logic [CNT_W-1:0] sync_age_r, sync_age_nxt;
  logic [CNT_W-1:0] lost_r, lost_nxt;
  logic [CNT_W-1:0] dup_r, dup_nxt;
  logic [CNT_W-1:0] ooo_r, ooo_nxt;

  logic             out_valid_r;
  result_t          out_r, out_nxt;

  logic [SEQ_W-1:0] fwd_diff, back_diff;
  logic [CNT_W:0]   lost_sum;
  logic             fresh;
  logic             start_eff;
  reply_t           reply;
  logic [SEQ_W-1:0] rseq;

  assign pop = q_not_empty & (~out_valid_r | out_ch.ready);

  assign fwd_diff  = q_head.seq - last_seq_r;
  assign back_diff = last_seq_r - q_head.seq;
  assign lost_sum  = {1'b0, lost_r} + {1'b0, fwd_diff - 1'b1};

  always_comb begin
    mode_nxt     = mode_r;
    started_nxt  = started_r;
    last_seq_nxt = last_seq_r;
    valid_nxt    = valid_r;
    level_nxt    = level_r;
    wd_nxt       = wd_r;
    data_age_nxt = data_age_r;
    sync_age_nxt = sync_age_r;
    lost_nxt     = lost_r;
    dup_nxt      = dup_r;
    ooo_nxt      = ooo_r;
    fresh        = 1'b0;
    reply        = RPL_NONE;
    rseq         = '0;
    start_eff    = started_r & ~q_head.newly;
    case (q_head.op)
      OP_TICK: begin
        data_age_nxt = (data_age_r == CNT_MAX) ? data_age_r : data_age_r + 1'b1;
        sync_age_nxt = (sync_age_r == CNT_MAX) ? sync_age_r : sync_age_r + 1'b1;
        if (valid_r && data_age_nxt > timeout_r) begin
          valid_nxt = 1'b0;
          wd_nxt    = '0;
          if (mode_r == LINK_CONN) begin
            mode_nxt    = LINK_STALE;
            started_nxt = 1'b0;
          end
        end
        if (mode_nxt == LINK_STALE && sync_age_nxt >= sync_int_r) begin
          sync_age_nxt = '0;
          reply        = RPL_SYNC;
        end
      end
      OP_HELLO: begin
        valid_nxt    = 1'b0;
        started_nxt  = 1'b0;
        last_seq_nxt = '0;
        reply        = RPL_ACK;
        mode_nxt     = LINK_CONN;
      end
      OP_LEVEL: begin
        reply = RPL_ACK;
        if (!start_eff) begin
          fresh = 1'b1;
        end else if (q_head.seq == last_seq_r) begin
          dup_nxt = (dup_r == CNT_MAX) ? dup_r : dup_r + 1'b1;
        end else if (q_head.seq < last_seq_r) begin
          if (back_diff > resync_r) begin
            fresh = 1'b1;
          end else begin
            ooo_nxt = (ooo_r == CNT_MAX) ? ooo_r : ooo_r + 1'b1;
          end
        end else begin
          fresh = 1'b1;
          if (lost_sum[CNT_W]) begin
            lost_nxt = CNT_MAX;
          end else begin
            lost_nxt = lost_sum[CNT_W-1:0];
          end
        end
        if (q_head.newly) begin
          last_seq_nxt = '0;
          started_nxt  = 1'b0;
        end
        if (fresh) begin
          last_seq_nxt = q_head.seq;
          started_nxt  = 1'b1;
          level_nxt    = q_head.level;
          wd_nxt       = q_head.dry_ind;
          data_age_nxt = '0;
          valid_nxt    = 1'b1;
          mode_nxt     = LINK_CONN;
        end
      end
      OP_PING: begin
        reply    = RPL_PONG;
        rseq     = q_head.seq;
        mode_nxt = LINK_CONN;
      end
      OP_BYE: begin
        valid_nxt = 1'b0;
        mode_nxt  = LINK_STALE;
      end
      OP_REJECT: begin
        reply = RPL_REJECT;
      end
      default: begin
        reply = RPL_NONE;
      end
    endcase

    out_nxt.reply              = reply;
    out_nxt.reply_seq          = rseq;
    out_nxt.link_state         = mode_nxt;
    out_nxt.data_valid         = valid_nxt;
    out_nxt.held_level         = level_nxt;
    out_nxt.held_dry_ind       = wd_nxt;
    out_nxt.fresh_data         = fresh;
    out_nxt.lost_total         = lost_nxt;
    out_nxt.duplicate_total    = dup_nxt;
    out_nxt.out_of_order_total = ooo_nxt;
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      sync_int_r <= SYNC_RST;
      resync_r   <= RESYNC_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TIMEOUT: timeout_r  <= cfg_ch.data;
        CFG_SYNC:    sync_int_r <= cfg_ch.data;
        CFG_RESYNC:  resync_r   <= cfg_ch.data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= LINK_DISC;
      started_r   <= 1'b0;
      last_seq_r  <= '0;
      valid_r     <= 1'b0;
      level_r     <= '0;
      wd_r        <= '0;
      data_age_r  <= '0;
      sync_age_r  <= '0;
      lost_r      <= '0;
      dup_r       <= '0;
      ooo_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mode_r     <= mode_nxt;
        started_r  <= started_nxt;
        last_seq_r <= last_seq_nxt;
        valid_r    <= valid_nxt;
        level_r    <= level_nxt;
        wd_r       <= wd_nxt;
        data_age_r <= data_age_nxt;
        sync_age_r <= sync_age_nxt;
        lost_r     <= lost_nxt;
        dup_r      <= dup_nxt;
        ooo_r      <= ooo_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.reply              = out_r.reply;
  assign out_ch.reply_seq          = out_r.reply_seq;
  assign out_ch.link_state         = out_r.link_state;
  assign out_ch.data_valid         = out_r.data_valid;
  assign out_ch.held_level         = out_r.held_level;
  assign out_ch.held_dry_ind       = out_r.held_dry_ind;
  assign out_ch.fresh_data         = out_r.fresh_data;
  assign out_ch.lost_total         = out_r.lost_total;
  assign out_ch.duplicate_total    = out_r.duplicate_total;
  assign out_ch.out_of_order_total = out_r.out_of_order_total;

  a_sync_when_stale: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_r.reply != RPL_SYNC || out_r.link_state == LINK_STALE))
    else $error("sync request outside stale link");

  a_fresh_connects: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (!out_r.fresh_data || (out_r.data_valid && out_r.link_state == LINK_CONN)))
    else $error("fresh data without valid connected link");

  a_pong_connected: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_r.reply != RPL_PONG || out_r.link_state == LINK_CONN))
    else $error("pong without connected link");

  a_snapshot_matches: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_r.lost_total == lost_r && out_r.data_valid == valid_r))
    else $error("result snapshot differs from state");

endmodule
